>>> src/fbdf_pkg.sv
`default_nettype none
package fbdf_pkg;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_DATA   = 3'd1,
		EV_OK     = 3'd2,
		EV_PING   = 3'd3,
		EV_PONG   = 3'd4,
		EV_LENERR = 3'd5,
		EV_SUMERR = 3'd6
	} fbdf_event_t;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_MARK,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_PAYLOAD,
		PH_CK_HI,
		PH_CK_LO
	} fbdf_phase_t;

	localparam logic [1:0] CFG_MAGIC = 2'd0;
	localparam logic [1:0] CFG_MAXLEN = 2'd1;
	localparam logic [1:0] CFG_PING = 2'd2;
	localparam logic [1:0] CFG_PONG = 2'd3;

	localparam logic [15:0] MAGIC_RST = 16'hC03E;
	localparam logic [8:0] MAXLEN_RST = 9'd256;
	localparam logic [7:0] PING_RST = 8'd1;
	localparam logic [7:0] PONG_RST = 8'd2;
	localparam logic [8:0] MOD_255 = 9'd255;
	localparam logic [15:0] FLEN_SAT = 16'd511;

	typedef struct packed {
		fbdf_event_t ev;
		logic [7:0] data;
		logic [7:0] idx;
		logic [8:0] flen;
	} fbdf_result_t;

	function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= MOD_255) begin
			s = s - MOD_255;
		end
		return s[7:0];
	endfunction

endpackage
`default_nettype wire

>>> src/framed_byte_deframer_fletcher.sv
`default_nettype none
// Channel   Handshake                Payload
// config    cfg_we                   cfg_index, cfg_data
// input     in_valid / in_stall      rx_byte
// output    out_valid / out_stall    event_res, data_byte, byte_index, frame_length
//
// One byte per cycle while in_stall is low; with the output not stalled, each accepted byte
// yields its result in the next cycle. Latency is set by the output register; a skid register
// holds one more result. in_stall rises only while the skid register is full.
// arst_n clears the phase, sums and configuration to their reset values.
module framed_byte_deframer_fletcher #(
	parameter int MAX_PAYLOAD = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       event_res,
	output logic [7:0]       data_byte,
	output logic [7:0]       byte_index,
	output logic [8:0]       frame_length
);
	import fbdf_pkg::*;

	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam logic [15:0] MAX_P16 = 16'(MAX_PAYLOAD);

	logic [15:0] magic_q;
	logic [8:0] max_len_q;
	logic [7:0] ping_q;
	logic [7:0] pong_q;

	fbdf_phase_t phase_q, phase_d;
	logic [7:0] len_hi_q, len_hi_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] cnt_q, cnt_d;
	logic [7:0] first_q, first_d;
	logic [7:0] sl_q, sl_d;
	logic [7:0] sh_q, sh_d;
	logic [7:0] ck_hi_q, ck_hi_d;
	fbdf_result_t res;

	fbdf_result_t out_q, skid_q;
	logic skid_valid_q;
	logic accept, take;

	logic [15:0] rx_len, limit16, len16, cnt16;
	logic [7:0] sl_new;

	assign in_stall = skid_valid_q;
	assign accept = in_valid && !skid_valid_q;
	assign take = out_valid && !out_stall;

	assign rx_len = {len_hi_q, rx_byte};
	assign limit16 = ({7'd0, max_len_q} > MAX_P16) ? MAX_P16 : {7'd0, max_len_q};
	assign len16 = 16'(len_q);
	assign cnt16 = 16'(cnt_q);
	assign sl_new = add_mod255(sl_q, rx_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= MAGIC_RST;
			max_len_q <= MAXLEN_RST;
			ping_q <= PING_RST;
			pong_q <= PONG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAGIC:  magic_q <= cfg_data;
				CFG_MAXLEN: max_len_q <= cfg_data[8:0];
				CFG_PING:   ping_q <= cfg_data[7:0];
				CFG_PONG:   pong_q <= cfg_data[7:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_hi_q <= '0;
			len_q <= '0;
			cnt_q <= '0;
			first_q <= '0;
			sl_q <= '0;
			sh_q <= '0;
			ck_hi_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			len_hi_q <= len_hi_d;
			len_q <= len_d;
			cnt_q <= cnt_d;
			first_q <= first_d;
			sl_q <= sl_d;
			sh_q <= sh_d;
			ck_hi_q <= ck_hi_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		len_hi_d = len_hi_q;
		len_d = len_q;
		cnt_d = cnt_q;
		first_d = first_q;
		sl_d = sl_q;
		sh_d = sh_q;
		ck_hi_d = ck_hi_q;
		res = '{ev: EV_NONE, data: 8'd0, idx: 8'd0, flen: 9'd0};
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == magic_q[15:8]) begin
					phase_d = PH_MARK;
				end
			end
			PH_MARK: begin
				if (rx_byte == magic_q[7:0]) begin
					phase_d = PH_LEN_HI;
				end else if (rx_byte == magic_q[15:8]) begin
					phase_d = PH_MARK;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_LEN_HI: begin
				len_hi_d = rx_byte;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				if (rx_len > limit16) begin
					res.ev = EV_LENERR;
					res.flen = (rx_len > FLEN_SAT) ? FLEN_SAT[8:0] : rx_len[8:0];
					phase_d = PH_HUNT;
					len_hi_d = '0;
					len_d = '0;
					first_d = '0;
					ck_hi_d = '0;
				end else begin
					len_d = rx_len[LEN_W-1:0];
					phase_d = (rx_len == 16'd0) ? PH_CK_HI : PH_PAYLOAD;
				end
				cnt_d = '0;
				sl_d = '0;
				sh_d = '0;
			end
			PH_PAYLOAD: begin
				if (cnt16 == 16'd0) begin
					first_d = rx_byte;
				end
				sl_d = sl_new;
				sh_d = add_mod255(sh_q, sl_new);
				res.ev = EV_DATA;
				res.data = rx_byte;
				res.idx = cnt16[7:0];
				cnt_d = cnt_q + LEN_W'(1);
				if (cnt16 == len16 - 16'd1) begin
					phase_d = PH_CK_HI;
				end
			end
			PH_CK_HI: begin
				ck_hi_d = rx_byte;
				phase_d = PH_CK_LO;
			end
			PH_CK_LO: begin
				res.flen = len16[8:0];
				if ({ck_hi_q, rx_byte} != {sh_q, sl_q}) begin
					res.ev = EV_SUMERR;
				end else if (len16 == 16'd1 && first_q == ping_q) begin
					res.ev = EV_PING;
				end else if (len16 == 16'd1 && first_q == pong_q) begin
					res.ev = EV_PONG;
				end else begin
					res.ev = EV_OK;
				end
				phase_d = PH_HUNT;
				len_hi_d = '0;
				len_d = '0;
				cnt_d = '0;
				first_d = '0;
				sl_d = '0;
				sh_d = '0;
				ck_hi_d = '0;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_valid && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid <= 1'b1;
			end
		end else if (take) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_valid && !take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign event_res = out_q.ev;
	assign data_byte = out_q.data;
	assign byte_index = out_q.idx;
	assign frame_length = out_q.flen;

endmodule
`default_nettype wire

>>> dv/tb_framed_byte_deframer_fletcher.sv
`timescale 1ns / 100ps
module tb_framed_byte_deframer_fletcher;
	import fbdf_pkg::*;

	localparam int MAX_PL = 256;
	localparam int LONG_HOLD = 300;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_MAGIC;
	logic [15:0] cfg_data = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  event_res;
	logic [7:0]  data_byte;
	logic [7:0]  byte_index;
	logic [8:0]  frame_length;

	framed_byte_deframer_fletcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.data_byte(data_byte),
		.byte_index(byte_index),
		.frame_length(frame_length)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// register copies
	logic [15:0] mg = MAGIC_RST;
	logic [8:0]  mx = MAXLEN_RST;
	logic [7:0]  pg = PING_RST;
	logic [7:0]  po = PONG_RST;

	// deframer state
	int unsigned pos = 0;
	logic [15:0] plen = 16'd0;
	logic [7:0]  first_pb = 8'd0;
	logic [7:0]  slo = 8'd0;
	logic [7:0]  shi = 8'd0;
	logic [7:0]  ckhi = 8'd0;

	logic [7:0]   feed_q[$];
	fbdf_result_t exp_q[$];
	fbdf_result_t want;

	int  n_fed = 0;
	int  n_sent = 0;
	int  n_res = 0;
	int  n_err = 0;
	int  ev_cnt [0:7];
	int  src_wait = 0;
	int  snk_wait = 0;
	int  hold_at = -1;
	bit  src_idle = 1'b0;
	bit  snk_idle = 1'b0;
	logic       nv;
	logic [7:0] nb;

	function automatic logic [7:0] fl_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= 9'd255) ? 8'(s - 9'd255) : s[7:0];
	endfunction

	function automatic void frame_clear();
		pos = 0;
		plen = 16'd0;
		first_pb = 8'd0;
		slo = 8'd0;
		shi = 8'd0;
		ckhi = 8'd0;
	endfunction

	function automatic fbdf_result_t deframe_step(input logic [7:0] b);
		fbdf_result_t r;
		logic [8:0]   lim;
		int unsigned  k;
		r = '0;
		r.ev = EV_NONE;
		if (pos == 0) begin
			if (b == mg[15:8])
				pos = 1;
		end else if (pos == 1) begin
			if (b == mg[7:0])
				pos = 2;
			else
				pos = (b == mg[15:8]) ? 1 : 0;
		end else if (pos == 2) begin
			plen = {b, 8'd0};
			pos = 3;
		end else if (pos == 3) begin
			plen[7:0] = b;
			lim = (mx > 9'(MAX_PL)) ? 9'(MAX_PL) : mx;
			if (plen > lim) begin
				r.ev = EV_LENERR;
				r.flen = (plen > 16'd511) ? 9'd511 : plen[8:0];
				frame_clear();
			end else begin
				slo = 8'd0;
				shi = 8'd0;
				pos = 4;
			end
		end else if (pos < 4 + plen) begin
			k = pos - 4;
			if (k == 0)
				first_pb = b;
			slo = fl_add(slo, b);
			shi = fl_add(shi, slo);
			r.ev = EV_DATA;
			r.data = b;
			r.idx = k[7:0];
			pos++;
		end else if (pos == 4 + plen) begin
			ckhi = b;
			pos++;
		end else begin
			r.flen = plen[8:0];
			if ({ckhi, b} != {shi, slo})
				r.ev = EV_SUMERR;
			else if (plen == 16'd1 && first_pb == pg)
				r.ev = EV_PING;
			else if (plen == 16'd1 && first_pb == po)
				r.ev = EV_PONG;
			else
				r.ev = EV_OK;
			frame_clear();
		end
		return r;
	endfunction

	function automatic int draw_wait(input bit on);
		return on ? int'($urandom_range(0, 15)) : 0;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want_v);
		$display("[%0t] result %0d: %s is %0d, expected %0d", $time, n_res, what, got, want_v);
		n_err++;
	endtask

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'd0;
		end else begin
			nv = 1'b0;
			nb = rx_byte;
			if (in_valid && !in_stall) begin
				exp_q.push_back(deframe_step(rx_byte));
				n_sent++;
				src_wait = draw_wait(src_idle);
			end
			if (in_valid && in_stall) begin
				nv = 1'b1;
			end else if (src_wait > 0) begin
				src_wait--;
			end else if (feed_q.size() != 0) begin
				nv = 1'b1;
				nb = feed_q.pop_front();
			end
			in_valid <= nv;
			rx_byte <= nb;
		end
	end

	// receiver
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (exp_q.size() == 0) begin
					flag_mismatch("unexpected transaction, event", event_res, EV_NONE);
				end else begin
					want = exp_q.pop_front();
					ev_cnt[want.ev]++;
					if (event_res !== want.ev)
						flag_mismatch("event_res", event_res, want.ev);
					if (data_byte !== want.data)
						flag_mismatch("data_byte", data_byte, want.data);
					if (byte_index !== want.idx)
						flag_mismatch("byte_index", byte_index, want.idx);
					if (frame_length !== want.flen)
						flag_mismatch("frame_length", frame_length, want.flen);
				end
				n_res++;
				snk_wait = (n_res == hold_at) ? LONG_HOLD : draw_wait(snk_idle);
			end
			if (snk_wait > 0) begin
				snk_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic feed(input logic [7:0] b);
		feed_q.push_back(b);
		n_fed++;
	endtask

	task automatic put_frame(input int len, input int first_val, input bit corrupt);
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [7:0]  b;
		logic [15:0] ck;
		lo = 8'd0;
		hi = 8'd0;
		feed(mg[15:8]);
		feed(mg[7:0]);
		feed(len[15:8]);
		feed(len[7:0]);
		for (int k = 0; k < len; k++) begin
			b = (k == 0 && first_val >= 0) ? first_val[7:0] : 8'($urandom_range(0, 255));
			lo = fl_add(lo, b);
			hi = fl_add(hi, lo);
			feed(b);
		end
		ck = {hi, lo};
		if (corrupt)
			ck = ck ^ 16'($urandom_range(1, 65535));
		feed(ck[15:8]);
		feed(ck[7:0]);
	endtask

	task automatic put_lenerr(input logic [15:0] len);
		feed(mg[15:8]);
		feed(mg[7:0]);
		feed(len[15:8]);
		feed(len[7:0]);
	endtask

	task automatic fill_random(input int n);
		int stop;
		int pick;
		int lim;
		stop = n_fed + n;
		lim = (mx > 9'(MAX_PL)) ? MAX_PL : int'(mx);
		while (n_fed < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				put_frame($urandom_range(0, (lim < 8) ? lim : 8), -1, $urandom_range(0, 6) == 0);
			end else if (pick < 68 && lim >= 1) begin
				put_frame(1, $urandom_range(0, 1) ? int'(pg) : int'(po),
					$urandom_range(0, 9) == 0);
			end else if (pick < 78) begin
				put_lenerr($urandom_range(0, 1) ? 16'(lim + 1) : 16'($urandom_range(lim + 1, 65535)));
			end else begin
				if (pick >= 92) begin
					feed(mg[15:8]);
					feed(mg[7:0]);
				end
				repeat ($urandom_range(1, 5))
					feed(($urandom_range(0, 3) == 0) ? mg[15:8] : 8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic wait_drain();
		do
			@(negedge clk);
		while (feed_q.size() != 0 || in_valid || exp_q.size() != 0);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MAGIC: mg = val;
			CFG_MAXLEN: mx = val[8:0];
			CFG_PING: pg = val[7:0];
			default: po = val[7:0];
		endcase
		@(negedge clk);
	endtask

	initial begin
		foreach (ev_cnt[i])
			ev_cnt[i] = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		feed(mg[15:8]);
		put_frame(0, -1, 1'b0);
		put_frame(1, PING_RST, 1'b0);
		put_lenerr(16'hFFFF);
		put_frame(1, PONG_RST, 1'b1);
		wait_drain();

		src_idle = 1'b1;
		snk_idle = 1'b1;
		hold_at = n_res + 40;
		fill_random(100);
		wait_drain();

		set_reg(CFG_MAGIC, 16'hFFFF);
		set_reg(CFG_MAXLEN, 16'd0);
		set_reg(CFG_PING, 16'h00FF);
		set_reg(CFG_PONG, 16'h0000);
		src_idle = 1'b1;
		snk_idle = 1'b0;
		fill_random(90);
		wait_drain();

		set_reg(CFG_MAGIC, 16'h0000);
		set_reg(CFG_MAXLEN, 16'hFFFF);
		set_reg(CFG_PING, 16'hA55A);
		set_reg(CFG_PONG, 16'h005A);
		src_idle = 1'b0;
		snk_idle = 1'b1;
		put_frame(MAX_PL, -1, 1'b0);
		put_lenerr(16'(MAX_PL + 1));
		fill_random(60);
		wait_drain();

		set_reg(CFG_MAGIC, 16'hAAAA);
		set_reg(CFG_MAXLEN, 16'd3);
		set_reg(CFG_PING, 16'h0000);
		set_reg(CFG_PONG, 16'h00FF);
		src_idle = 1'b1;
		snk_idle = 1'b1;
		hold_at = n_res + 20;
		fill_random(60);
		wait_drain();
		fill_random(60);
		wait_drain();

		set_reg(CFG_MAGIC, 16'h7E81);
		set_reg(CFG_MAXLEN, 16'd200);
		set_reg(CFG_PING, 16'h0080);
		set_reg(CFG_PONG, 16'h007F);
		src_idle = 1'b0;
		snk_idle = 1'b0;
		fill_random(50);
		wait_drain();
		repeat (16) @(negedge clk);

		$display("%0d bytes in, %0d results checked across five register settings, %0d payload bytes",
			n_sent, n_res, ev_cnt[EV_DATA]);
		$display("frame endings: %0d good, %0d ping, %0d pong, %0d bad length, %0d bad checksum",
			ev_cnt[EV_OK], ev_cnt[EV_PING], ev_cnt[EV_PONG], ev_cnt[EV_LENERR],
			ev_cnt[EV_SUMERR]);
		if (n_err == 0)
			$display("tb_framed_byte_deframer_fletcher OK");
		else
			$display("tb_framed_byte_deframer_fletcher NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d transactions outstanding", exp_q.size());
		$display("tb_framed_byte_deframer_fletcher NOT OK");
		$finish;
	end

endmodule

>>> framed_byte_deframer_fletcher.f
src/fbdf_pkg.sv
src/framed_byte_deframer_fletcher.sv
dv/tb_framed_byte_deframer_fletcher.sv
